/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* hdl/prlf_pkg.sv */
`timescale 1ns / 1ps

package prlf_pkg;

  // Field widths
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int RAY_BITS   = 4 + FRAC_BITS;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int INV_BITS    = 32;
  localparam int CENTER_BITS = 16;
  localparam int FRAME_BITS  = 13;

  // Offset datapath widths
  localparam int MAG_BITS = (COORD_BITS + 4 > CENTER_BITS) ? COORD_BITS + 4 : CENTER_BITS;
  localparam int CMP_BITS = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;
  localparam int PROD_BITS    = MAG_BITS + INV_BITS;
  localparam int OFFSET_SHIFT = 36 - FRAC_BITS;
  localparam int Q_BITS       = PROD_BITS + 1 - OFFSET_SHIFT;
  localparam int SQ_BITS      = 2 * RAY_BITS;
  localparam int SUM_BITS     = 2 * RAY_BITS + 2;
  localparam int ROOT_BITS    = RAY_BITS + 1;

  // Square root pipeline: root bits resolved per stage
  localparam int SQRT_STEPS  = 4;
  localparam int SQRT_STAGES = (ROOT_BITS + SQRT_STEPS - 1) / SQRT_STEPS;

  // Five front stages, the root stages, one output stage
  localparam int PIPE_LATENCY = 5 + SQRT_STAGES + 1;

  localparam logic [RAY_BITS-1:0] RAY_MAX = {RAY_BITS{1'b1}};
  localparam logic [RAY_BITS-1:0] RAY_ONE = RAY_BITS'(1) << FRAC_BITS;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_INV_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INV_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd5;

  // Register reset values
  localparam logic [INV_BITS-1:0]    INV_FOCAL_RST    = {INV_BITS{1'b1}};
  localparam logic [CENTER_BITS-1:0] CENTER_RST       = '0;
  localparam logic [FRAME_BITS-1:0]  FRAME_WIDTH_RST  = FRAME_BITS'(640);
  localparam logic [FRAME_BITS-1:0]  FRAME_HEIGHT_RST = FRAME_BITS'(480);

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
  } prlf_in_t;

  typedef struct packed {
    logic [RAY_BITS-1:0] ray_factor;
    logic                out_of_frame;
    logic                saturated;
  } prlf_out_t;

  // Flags that ride along the square root pipeline
  typedef struct packed {
    logic big;
    logic oof;
  } prlf_side_t;

endpackage

/* hdl/pinhole_ray_length_factor.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------------
// input     start / busy         in_data   (pixel_col, pixel_row)
// result    out_strobe           out_data  (ray_factor, out_of_frame, saturated)
// config    cfg_we               cfg_index, cfg_wdata
//
// One pixel enters per clock; busy stays low. Each result appears for one cycle
// with out_strobe high once its beat has passed through the pipeline, which
// is made of five front stages (offset, multiply, round, square,
// sum), a six-stage square root resolving four root bits per stage, and the
// output register. Synchronous active-low reset clears all valid bits and
// loads the register defaults. The result side cannot stall, so the pipeline
// advances every cycle.
module pinhole_ray_length_factor import prlf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  prlf_in_t                 in_data,
  output logic                     out_strobe,
  output prlf_out_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam logic [PROD_BITS:0] RND_HALF = (PROD_BITS + 1)'(1) << (OFFSET_SHIFT - 1);
  localparam logic [SUM_BITS-1:0] ONE_SQ  = SUM_BITS'(1) << (2 * FRAC_BITS);

  // Configuration registers
  logic [INV_BITS-1:0]    inv_fx_r, inv_fy_r;
  logic [CENTER_BITS-1:0] ctr_x_r, ctr_y_r;
  logic [FRAME_BITS-1:0]  frame_w_r, frame_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_fx_r  <= INV_FOCAL_RST;
      inv_fy_r  <= INV_FOCAL_RST;
      ctr_x_r   <= CENTER_RST;
      ctr_y_r   <= CENTER_RST;
      frame_w_r <= FRAME_WIDTH_RST;
      frame_h_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_FOCAL_X:  inv_fx_r  <= cfg_wdata[INV_BITS-1:0];
        CFG_INV_FOCAL_Y:  inv_fy_r  <= cfg_wdata[INV_BITS-1:0];
        CFG_CENTER_X:     ctr_x_r   <= cfg_wdata[CENTER_BITS-1:0];
        CFG_CENTER_Y:     ctr_y_r   <= cfg_wdata[CENTER_BITS-1:0];
        CFG_FRAME_WIDTH:  frame_w_r <= cfg_wdata[FRAME_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_h_r <= cfg_wdata[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Fully pipelined: a beat is taken every cycle
  logic acc;
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Stage A: offsets from the principal point, frame check
  logic [MAG_BITS-1:0] px16, py16, cx_ext, cy_ext, magx_nxt, magy_nxt;
  logic                oof_nxt;
  logic [MAG_BITS-1:0] magx_a_r, magy_a_r;
  logic                oof_a_r, vld_a_r;

  always_comb begin
    px16     = MAG_BITS'({in_data.pixel_col, 4'b0000});
    py16     = MAG_BITS'({in_data.pixel_row, 4'b0000});
    cx_ext   = MAG_BITS'(ctr_x_r);
    cy_ext   = MAG_BITS'(ctr_y_r);
    magx_nxt = (px16 >= cx_ext) ? px16 - cx_ext : cx_ext - px16;
    magy_nxt = (py16 >= cy_ext) ? py16 - cy_ext : cy_ext - py16;
    oof_nxt  = (CMP_BITS'(in_data.pixel_col) >= CMP_BITS'(frame_w_r)) ||
               (CMP_BITS'(in_data.pixel_row) >= CMP_BITS'(frame_h_r));
  end

  // Stage B: scale by the reciprocal focal lengths
  logic [PROD_BITS-1:0] mx_b_r, my_b_r;
  logic                 oof_b_r, vld_b_r;

  // Stage C: round to FRAC_BITS, flag large offsets
  logic [PROD_BITS:0]  rndx_nxt, rndy_nxt;
  logic [Q_BITS-1:0]   qx_full, qy_full;
  logic                big_nxt;
  logic [RAY_BITS-1:0] qx_c_r, qy_c_r;
  logic                big_c_r, oof_c_r, vld_c_r;

  always_comb begin
    rndx_nxt = {1'b0, mx_b_r} + RND_HALF;
    rndy_nxt = {1'b0, my_b_r} + RND_HALF;
    qx_full  = rndx_nxt[PROD_BITS:OFFSET_SHIFT];
    qy_full  = rndy_nxt[PROD_BITS:OFFSET_SHIFT];
    big_nxt  = (|qx_full[Q_BITS-1:RAY_BITS]) || (|qy_full[Q_BITS-1:RAY_BITS]);
  end

  // Stage D: squares
  logic [SQ_BITS-1:0] sqx_d_r, sqy_d_r;
  logic               big_d_r, oof_d_r, vld_d_r;

  // Stage E: radicand
  logic [SUM_BITS-1:0] rad_e_r;
  prlf_side_t          side_e_r;
  logic                vld_e_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else begin
      vld_a_r <= acc;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    magx_a_r <= magx_nxt;
    magy_a_r <= magy_nxt;
    oof_a_r  <= oof_nxt;

    mx_b_r  <= PROD_BITS'(magx_a_r) * PROD_BITS'(inv_fx_r);
    my_b_r  <= PROD_BITS'(magy_a_r) * PROD_BITS'(inv_fy_r);
    oof_b_r <= oof_a_r;

    qx_c_r  <= qx_full[RAY_BITS-1:0];
    qy_c_r  <= qy_full[RAY_BITS-1:0];
    big_c_r <= big_nxt;
    oof_c_r <= oof_b_r;

    sqx_d_r <= SQ_BITS'(qx_c_r) * SQ_BITS'(qx_c_r);
    sqy_d_r <= SQ_BITS'(qy_c_r) * SQ_BITS'(qy_c_r);
    big_d_r <= big_c_r;
    oof_d_r <= oof_c_r;

    rad_e_r      <= SUM_BITS'(sqx_d_r) + SUM_BITS'(sqy_d_r) + ONE_SQ;
    side_e_r.big <= big_d_r;
    side_e_r.oof <= oof_d_r;
  end

  // Square root
  logic                 root_vld;
  logic [ROOT_BITS-1:0] root;
  prlf_side_t           root_side;

  prlf_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_e_r),
    .in_rad    (rad_e_r),
    .in_side   (side_e_r),
    .out_valid (root_vld),
    .out_root  (root),
    .out_side  (root_side)
  );

  // Output stage: clip to the maximum
  logic      sat_nxt;
  prlf_out_t out_nxt;
  prlf_out_t out_r;
  logic      strobe_r;

  always_comb begin
    sat_nxt              = root_side.big || root[RAY_BITS];
    out_nxt.ray_factor   = sat_nxt ? RAY_MAX : root[RAY_BITS-1:0];
    out_nxt.out_of_frame = root_side.oof;
    out_nxt.saturated    = sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  // Every taken beat yields one result after the fixed latency
  `ASSERT_PROP(a_latency, clk, rst_n, (start && !busy) |-> ##PIPE_LATENCY out_strobe)
  // A clipped result carries the maximum factor
  `ASSERT_NEVER(a_sat_max, clk, rst_n,
    out_strobe && out_data.saturated && (out_data.ray_factor != RAY_MAX))
  // The factor is never below one
  `ASSERT_NEVER(a_factor_floor, clk, rst_n,
    out_strobe && (out_data.ray_factor < RAY_ONE))

endmodule

/* hdl/prlf_sqrt_pipe.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Pipelined integer square root, SQRT_STEPS root bits per stage.
module prlf_sqrt_pipe import prlf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [SUM_BITS-1:0]  in_rad,
  input  prlf_side_t           in_side,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] out_root,
  output prlf_side_t           out_side
);

  // Stage inputs (index 0 is the module input)
  logic [SUM_BITS-1:0]  rad_s  [SQRT_STAGES];
  logic [ROOT_BITS-1:0] root_s [SQRT_STAGES];
  logic [ROOT_BITS+1:0] rem_s  [SQRT_STAGES];
  prlf_side_t           side_s [SQRT_STAGES];
  logic                 vld_s  [SQRT_STAGES];

  // Stage registers; the last stage keeps only root, flags and valid
  logic [SUM_BITS-1:0]  rad_r  [SQRT_STAGES-1];
  logic [ROOT_BITS+1:0] rem_r  [SQRT_STAGES-1];
  logic [ROOT_BITS-1:0] root_r [SQRT_STAGES];
  prlf_side_t           side_r [SQRT_STAGES];
  logic                 vld_r  [SQRT_STAGES];

  assign rad_s[0]  = in_rad;
  assign root_s[0] = '0;
  assign rem_s[0]  = '0;
  assign side_s[0] = in_side;
  assign vld_s[0]  = in_valid;

  for (genvar st = 0; st < SQRT_STAGES; st++) begin : g_stage
    logic [SUM_BITS-1:0]  rad_nxt;
    logic [ROOT_BITS-1:0] root_nxt;
    logic [ROOT_BITS+1:0] rem_nxt;

    // Resolve the next root bits by restoring trial subtraction
    always_comb begin
      logic [ROOT_BITS+1:0] trial;
      rad_nxt  = rad_s[st];
      root_nxt = root_s[st];
      rem_nxt  = rem_s[st];
      trial    = '0;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        if (st * SQRT_STEPS + j < ROOT_BITS) begin
          rem_nxt = {rem_nxt[ROOT_BITS-1:0], rad_nxt[SUM_BITS-1 -: 2]};
          rad_nxt = rad_nxt << 2;
          trial   = {root_nxt, 2'b01};
          if (rem_nxt >= trial) begin
            rem_nxt  = rem_nxt - trial;
            root_nxt = {root_nxt[ROOT_BITS-2:0], 1'b1};
          end else begin
            root_nxt = {root_nxt[ROOT_BITS-2:0], 1'b0};
          end
        end
      end
    end

    // Advance valid every cycle
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else begin
        vld_r[st] <= vld_s[st];
      end
    end

    always_ff @(posedge clk) begin
      root_r[st] <= root_nxt;
      side_r[st] <= side_s[st];
    end

    if (st < SQRT_STAGES - 1) begin : g_mid
      always_ff @(posedge clk) begin
        rad_r[st] <= rad_nxt;
        rem_r[st] <= rem_nxt;
      end
      assign rad_s[st+1]  = rad_r[st];
      assign rem_s[st+1]  = rem_r[st];
      assign root_s[st+1] = root_r[st];
      assign side_s[st+1] = side_r[st];
      assign vld_s[st+1]  = vld_r[st];
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];
  assign out_side  = side_r[SQRT_STAGES-1];

  // A beat that enters leaves after passing through every stage register
  `ASSERT_PROP(a_sqrt_latency, clk, rst_n, in_valid |-> ##SQRT_STAGES out_valid)
  `ASSERT_PROP(a_sqrt_no_ghost, clk, rst_n, !in_valid |-> ##SQRT_STAGES !out_valid)
  // The radicand is at least one squared, so the root is at least one
  `ASSERT_NEVER(a_sqrt_floor, clk, rst_n,
    out_valid && (out_root < ROOT_BITS'(RAY_ONE)))

endmodule

/* bench/tb_pinhole_ray_length_factor.sv */
`timescale 1ns / 1ps

module tb_pinhole_ray_length_factor;
  import prlf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SCENE_COUNT   = 12;
  localparam int SCENE_PIXELS  = 160;
  localparam int REPORT_LIMIT  = 10;
  // Indexes past the last register: writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = CFG_FRAME_HEIGHT + 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = CFG_FRAME_HEIGHT + 3'd2;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  prlf_in_t                 in_data;
  logic                     out_strobe;
  prlf_out_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  // Camera registers as the block should hold them
  logic [INV_BITS-1:0]    cam_inv_x;
  logic [INV_BITS-1:0]    cam_inv_y;
  logic [CENTER_BITS-1:0] cam_cx;
  logic [CENTER_BITS-1:0] cam_cy;
  logic [FRAME_BITS-1:0]  cam_fw;
  logic [FRAME_BITS-1:0]  cam_fh;

  prlf_out_t pending_rays[$];
  int        err_count;
  int        cycle_count;
  int        idle_pct;

  pinhole_ray_length_factor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offset from the principal point in focal units, rounded half up
  function automatic logic [63:0] axis_offset(input logic [COORD_BITS-1:0] pix,
                                              input logic [CENTER_BITS-1:0] ctr,
                                              input logic [INV_BITS-1:0] inv);
    logic [63:0] p16;
    logic [63:0] mag;
    p16 = {48'd0, pix, 4'd0};
    mag = (p16 >= 64'(ctr)) ? p16 - 64'(ctr) : 64'(ctr) - p16;
    return (mag * 64'(inv) + (64'd1 << (OFFSET_SHIFT - 1))) >> OFFSET_SHIFT;
  endfunction

  // Expected factor and flags for one pixel under the current camera
  function automatic prlf_out_t ray_factor_of(input prlf_in_t px);
    logic [63:0] qx;
    logic [63:0] qy;
    logic [63:0] sum;
    logic [63:0] root;
    logic [63:0] trial;
    prlf_out_t   r;
    qx = axis_offset(px.pixel_col, cam_cx, cam_inv_x);
    qy = axis_offset(px.pixel_row, cam_cy, cam_inv_y);
    r.saturated = 1'b0;
    if (qx >= (64'd1 << RAY_BITS) || qy >= (64'd1 << RAY_BITS)) begin
      r.ray_factor = RAY_MAX;
      r.saturated  = 1'b1;
    end else begin
      sum  = qx * qx + qy * qy + (64'd1 << (2 * FRAC_BITS));
      root = '0;
      // Build the floor root one bit at a time from the top
      for (int b = 23; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= sum) root = trial;
      end
      if (root > 64'(RAY_MAX)) begin
        r.ray_factor = RAY_MAX;
        r.saturated  = 1'b1;
      end else begin
        r.ray_factor = root[RAY_BITS-1:0];
      end
    end
    r.out_of_frame = (13'(px.pixel_col) >= cam_fw) || (13'(px.pixel_row) >= cam_fh);
    return r;
  endfunction

  // Clamp a coordinate guess into the pixel range
  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > (1 << COORD_BITS) - 1) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  // Realistic, zero, full-scale or arbitrary reciprocal focal length
  function automatic logic [31:0] pick_inv();
    logic [63:0] q;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: begin
        q = (64'd1 << 32) / 64'($urandom_range(32, 8192));
        return q[31:0];
      end
    endcase
  endfunction

  // Frame size with junk above the register width
  function automatic logic [31:0] pick_frame();
    logic [31:0] junk;
    junk = $urandom & 32'hFFFF_E000;
    case ($urandom_range(0, 9))
      0: return junk;
      1: return junk | 32'h1FFF;
      2: return junk | 32'd4096;
      default: return junk | 32'($urandom_range(1, 4096));
    endcase
  endfunction

  // Check results, record accepted beats, track register writes
  always @(posedge clk) begin
    prlf_out_t want;
    if (!rst_n) begin
      cam_inv_x = INV_FOCAL_RST;
      cam_inv_y = INV_FOCAL_RST;
      cam_cx    = CENTER_RST;
      cam_cy    = CENTER_RST;
      cam_fw    = FRAME_WIDTH_RST;
      cam_fh    = FRAME_HEIGHT_RST;
    end else begin
      if (out_strobe) begin
        if (pending_rays.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("unexpected result: factor %h oof %b sat %b",
                     out_data.ray_factor, out_data.out_of_frame, out_data.saturated);
        end else begin
          want = pending_rays.pop_front();
          if (want.ray_factor !== out_data.ray_factor ||
              want.out_of_frame !== out_data.out_of_frame ||
              want.saturated !== out_data.saturated) begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
              $display("bad result: factor %h/%h oof %b/%b sat %b/%b (expected/actual)",
                       want.ray_factor, out_data.ray_factor,
                       want.out_of_frame, out_data.out_of_frame,
                       want.saturated, out_data.saturated);
          end
        end
      end
      if (start && !busy) pending_rays.push_back(ray_factor_of(in_data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_FOCAL_X:  cam_inv_x = cfg_wdata[INV_BITS-1:0];
          CFG_INV_FOCAL_Y:  cam_inv_y = cfg_wdata[INV_BITS-1:0];
          CFG_CENTER_X:     cam_cx    = cfg_wdata[CENTER_BITS-1:0];
          CFG_CENTER_Y:     cam_cy    = cfg_wdata[CENTER_BITS-1:0];
          CFG_FRAME_WIDTH:  cam_fw    = cfg_wdata[FRAME_BITS-1:0];
          CFG_FRAME_HEIGHT: cam_fh    = cfg_wdata[FRAME_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pinhole_ray_length_factor: mismatch");
      $finish;
    end
  end

  // Send one pixel beat, idling first when the current mix says so
  task automatic send_pixel(input int col, input int row);
    prlf_in_t px;
    px.pixel_col = clamp_coord(col);
    px.pixel_row = clamp_coord(row);
    // Idle each cycle with the current probability
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drive one register write beat; the caller drops the enable
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Program the whole camera, plus writes to unused indexes
  task automatic load_camera(input logic [31:0] inv_x, input logic [31:0] inv_y,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] fw, input logic [31:0] fh);
    write_reg(CFG_INV_FOCAL_X, inv_x);
    write_reg(CFG_INV_FOCAL_Y, inv_y);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
  endtask

  // Stop sending and let the pipeline empty out
  task automatic settle();
    start <= 1'b0;
    while (pending_rays.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Defaults after reset: unit focal scale, origin at pixel zero, 640x480
  task automatic test_reset_defaults();
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(15, 15);
    send_pixel(16, 0);
    send_pixel(639, 479);
    send_pixel(640, 0);
    send_pixel(0, 480);
    send_pixel(4095, 4095);
    settle();
  endtask

  // Zero focal reciprocal gives a flat factor of one; zero frame flags all
  task automatic test_zero_focal_empty_frame();
    load_camera('0, '0, 32'hABCD_FFFF, 32'h1234_FFFF, 32'hFFFF_E000, 32'h0000_2000);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2048, 1);
    settle();
  endtask

  // Focal length 256: offsets near 16 on one or both axes, oversized frame
  task automatic test_saturation_edges();
    load_camera(32'h0100_0000, 32'h0100_0000, '0, '0, 32'h1FFF, 32'd4096);
    send_pixel(3072, 3072);
    send_pixel(2048, 0);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(4095, 4095);
    send_pixel(2900, 2900);
    settle();
  endtask

  // Principal point at the middle of the pixel range, realistic focal length
  task automatic test_centered_camera();
    load_camera(32'h0041_8937, 32'h0041_8937, 32'd32768, 32'd32776, 32'd4095, 32'd1);
    send_pixel(2048, 2048);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4094, 0);
    send_pixel(2047, 2049);
    settle();
  endtask

  // Random cameras and pixels, aimed at frame edges and the principal point
  task automatic test_random_scenes();
    int pick;
    int col;
    int row;
    for (int scene = 0; scene < SCENE_COUNT; scene++) begin
      idle_pct   = (scene < 4) ? 34 : (scene < 8) ? 48 : 0;
      if (scene == 3)
        load_camera('1, '1, '1, '1, '1, '1);
      else if (scene == 7)
        load_camera('0, '0, '0, '0, '0, '0);
      else
        load_camera(pick_inv(), pick_inv(),
                    $urandom, $urandom, pick_frame(), pick_frame());
      repeat (SCENE_PIXELS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          col = $urandom_range(0, 4095);
          row = $urandom_range(0, 4095);
        end else if (pick < 85) begin
          col = int'(cam_fw) - 1 + $urandom_range(0, 2);
          row = int'(cam_fh) - 1 + $urandom_range(0, 2);
          if ($urandom_range(0, 1)) col = $urandom_range(0, 4095);
          else row = $urandom_range(0, 4095);
        end else begin
          col = int'(cam_cx >> 4) + $urandom_range(0, 8) - 4;
          row = int'(cam_cy >> 4) + $urandom_range(0, 8) - 4;
        end
        send_pixel(col, row);
      end
      settle();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    idle_pct    = 34;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_focal_empty_frame();
    test_saturation_edges();
    test_centered_camera();
    test_random_scenes();

    // Anything still waiting here never came out
    if (err_count == 0 && pending_rays.size() == 0) begin
      $display("pinhole_ray_length_factor: match");
    end else begin
      $display("pinhole_ray_length_factor: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/prlf_pkg.sv
hdl/prlf_sqrt_pipe.sv
hdl/pinhole_ray_length_factor.sv
bench/tb_pinhole_ray_length_factor.sv
